// File: hw/rtl/assert_macros.svh
// Assertion macros for the sampler RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/brs_pkg.sv
// Shared constants and types of the bilinear RGB sampler
package brs_pkg;
  localparam int SAMPLE_W    = 21;
  localparam int COORD_W     = 13;
  localparam int INDEX_W     = 16;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 24;
  localparam int ADDR_CALC_W = 2 * COORD_W + 1;
  localparam int NEIGHBOURS  = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam int N_TL = 0;
  localparam int N_TR = 1;
  localparam int N_BL = 2;
  localparam int N_BR = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic                  is_sample;
    logic                  out_of_range;
    logic [NEIGHBOURS-1:0] in_store;
  } ctl_t;
endpackage

// File: hw/rtl/brs_fifo.sv
// Short transaction queue between the front and back parts
module brs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slots [brs_pkg::QUEUE_DEPTH];
  logic [brs_pkg::QPTR_W-1:0] wr_ptr;
  logic [brs_pkg::QPTR_W-1:0] rd_ptr;
  logic [brs_pkg::QPTR_W:0]   count;
  logic push;
  logic pop;

  assign push_ready = count != (brs_pkg::QPTR_W+1)'(brs_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// File: hw/rtl/brs_front.sv
// Front part: accept transactions, split sample points, form store addresses
module brs_front #(
  parameter int FRAC_BITS  = 8,
  parameter int MAX_PIXELS = 65536,
  localparam int AW = $clog2(MAX_PIXELS)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [brs_pkg::COORD_W-1:0]             image_width,
  input  logic [brs_pkg::COORD_W-1:0]             image_height,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    kind,
  input  logic [brs_pkg::INDEX_W-1:0]             write_index,
  input  logic [brs_pkg::CH_W-1:0]                write_red,
  input  logic [brs_pkg::CH_W-1:0]                write_green,
  input  logic [brs_pkg::CH_W-1:0]                write_blue,
  input  logic [brs_pkg::SAMPLE_W-1:0]            sample_x,
  input  logic [brs_pkg::SAMPLE_W-1:0]            sample_y,
  output logic                                    q_valid,
  input  logic                                    q_ready,
  output brs_pkg::ctl_t                           q_ctl,
  output logic [brs_pkg::NEIGHBOURS-1:0][AW-1:0]  q_addr,
  output logic signed [FRAC_BITS:0]               q_dx,
  output logic signed [FRAC_BITS:0]               q_dy,
  output logic [brs_pkg::PIX_W-1:0]               q_pixel
);
  localparam int SW = brs_pkg::SAMPLE_W;
  localparam int CW = brs_pkg::COORD_W;
  localparam int XW = brs_pkg::ADDR_CALC_W;
  localparam int CMPW = SW + CW + FRAC_BITS;
  localparam int SPLIT_W = 2 * CW + FRAC_BITS + 1;
  localparam logic [SW:0] HALF = (SW+1)'(1) << (FRAC_BITS - 1);

  function automatic logic [SPLIT_W-1:0] split_axis(
    input logic [SW-1:0] v,
    input logic [CW-1:0] size
  );
    logic [SW:0]        s;
    logic               neg;
    logic [CW-1:0]      lo;
    logic [CW:0]        lo_inc;
    logic [CW-1:0]      hi;
    logic [FRAC_BITS:0] fr;
    s      = {1'b0, v} - HALF;
    neg    = s[SW];
    lo     = neg ? '0 : CW'(s[SW-1:FRAC_BITS]);
    lo_inc = {1'b0, lo} + 1'b1;
    hi     = (lo_inc >= {1'b0, size}) ? size - 1'b1 : lo_inc[CW-1:0];
    fr     = neg ? s[FRAC_BITS:0] : {1'b0, s[FRAC_BITS-1:0]};
    return {lo, hi, fr};
  endfunction

  logic                          valid;
  logic                          is_sample;
  logic                          out_of_range;
  logic [CW-1:0]                 xl, xr, yt, yb;
  logic signed [FRAC_BITS:0]     dx, dy;
  logic [brs_pkg::PIX_W-1:0]     pixel;
  logic [brs_pkg::INDEX_W-1:0]   windex;

  logic [SPLIT_W-1:0] split_x, split_y;
  logic               oor_next;
  logic [2*CW-1:0]    row_top, row_bot;
  logic [XW-1:0]      addr_calc [brs_pkg::NEIGHBOURS];
  logic [XW-1:0]      widx_ext;

  always_comb begin
    split_x  = split_axis(sample_x, image_width);
    split_y  = split_axis(sample_y, image_height);
    oor_next = (sample_x == '0) || (sample_y == '0) ||
               (CMPW'(sample_x) >= CMPW'({image_width, {FRAC_BITS{1'b0}}})) ||
               (CMPW'(sample_y) >= CMPW'({image_height, {FRAC_BITS{1'b0}}}));
  end

  assign in_ready = !valid || q_ready;
  assign q_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      is_sample    <= kind == brs_pkg::KIND_SAMPLE;
      out_of_range <= oor_next;
      xl           <= split_x[SPLIT_W-1 -: CW];
      xr           <= split_x[FRAC_BITS+CW -: CW];
      dx           <= split_x[FRAC_BITS:0];
      yt           <= split_y[SPLIT_W-1 -: CW];
      yb           <= split_y[FRAC_BITS+CW -: CW];
      dy           <= split_y[FRAC_BITS:0];
      pixel        <= {write_red, write_green, write_blue};
      windex       <= write_index;
    end
  end

  always_comb begin
    row_top = yt * image_width;
    row_bot = yb * image_width;
    addr_calc[brs_pkg::N_TL] = XW'(xl) + XW'(row_top);
    addr_calc[brs_pkg::N_TR] = XW'(xr) + XW'(row_top);
    addr_calc[brs_pkg::N_BL] = XW'(xl) + XW'(row_bot);
    addr_calc[brs_pkg::N_BR] = XW'(xr) + XW'(row_bot);
    widx_ext = XW'(windex);
    if (!is_sample) begin
      addr_calc[brs_pkg::N_TL] = widx_ext;
    end
    for (int i = 0; i < brs_pkg::NEIGHBOURS; i++) begin
      q_addr[i]         = addr_calc[i][AW-1:0];
      q_ctl.in_store[i] = addr_calc[i] < XW'(MAX_PIXELS);
    end
    q_ctl.is_sample    = is_sample;
    q_ctl.out_of_range = out_of_range;
    q_dx    = dx;
    q_dy    = dy;
    q_pixel = pixel;
  end
endmodule

// File: hw/rtl/brs_back.sv
// Back part: four-port pixel store, bilinear blend, result register
`include "assert_macros.svh"
module brs_back #(
  parameter int FRAC_BITS  = 8,
  parameter int MAX_PIXELS = 65536,
  localparam int AW = $clog2(MAX_PIXELS)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  output logic                                    q_ready,
  input  brs_pkg::ctl_t                           q_ctl,
  input  logic [brs_pkg::NEIGHBOURS-1:0][AW-1:0]  q_addr,
  input  logic signed [FRAC_BITS:0]               q_dx,
  input  logic signed [FRAC_BITS:0]               q_dy,
  input  logic [brs_pkg::PIX_W-1:0]               q_pixel,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [brs_pkg::CH_W-1:0]                red,
  output logic [brs_pkg::CH_W-1:0]                green,
  output logic [brs_pkg::CH_W-1:0]                blue,
  output logic                                    out_of_range,
  output logic                                    clipped
);
  localparam int NB = brs_pkg::NEIGHBOURS;
  localparam int WW = FRAC_BITS + 2;
  localparam int TW = FRAC_BITS + 12;
  localparam int SUMW = 2 * FRAC_BITS + 15;
  localparam int CH_W_S = brs_pkg::CH_W + 1;
  localparam logic signed [WW-1:0] ONE = WW'(1) << FRAC_BITS;
  localparam logic signed [SUMW-1:0] LO_LIM = '0 - (SUMW'(1) << (2 * FRAC_BITS));
  localparam logic signed [SUMW-1:0] HI_LIM = SUMW'(256) << (2 * FRAC_BITS);

  logic advance;
  logic pop;

  logic                          v1;
  logic                          oor1;
  logic [NB-1:0]                 in_store1;
  logic [brs_pkg::PIX_W-1:0]     rd [NB];
  logic signed [FRAC_BITS:0]     dx1, dy1;

  logic                          v2;
  logic                          oor2;
  logic signed [TW-1:0]          top2 [3];
  logic signed [TW-1:0]          bot2 [3];
  logic signed [FRAC_BITS:0]     dy2;

  logic [brs_pkg::PIX_W-1:0]     pix [NB];
  logic signed [WW-1:0]          w1x, w0x, w1y, w0y;
  logic signed [CH_W_S-1:0]      chan [NB][3];
  logic signed [TW-1:0]          top_next [3];
  logic signed [TW-1:0]          bot_next [3];
  logic signed [SUMW-1:0]        sum [3];
  logic [brs_pkg::CH_W-1:0]      q [3];
  logic [2:0]                    clip_c;

  assign advance = !out_valid || out_ready;
  assign q_ready = advance;
  assign pop     = advance && q_valid;

  for (genvar n = 0; n < NB; n++) begin : g_bank
    logic [brs_pkg::PIX_W-1:0] mem [MAX_PIXELS];
    always_ff @(posedge clk) begin
      if (pop && !q_ctl.is_sample && q_ctl.in_store[brs_pkg::N_TL]) begin
        mem[q_addr[brs_pkg::N_TL]] <= q_pixel;
      end
      if (advance) begin
        rd[n] <= mem[q_addr[n]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oor1      <= q_ctl.out_of_range;
      in_store1 <= q_ctl.in_store;
      dx1       <= q_dx;
      dy1       <= q_dy;
      oor2      <= oor1;
      dy2       <= dy1;
      for (int c = 0; c < 3; c++) begin
        top2[c] <= top_next[c];
        bot2[c] <= bot_next[c];
      end
    end
  end

  always_comb begin
    w1x = {dx1[FRAC_BITS], dx1};
    w0x = ONE - w1x;
    for (int n = 0; n < NB; n++) begin
      pix[n] = in_store1[n] ? rd[n] : '0;
      for (int c = 0; c < 3; c++) begin
        chan[n][c] = {1'b0, pix[n][brs_pkg::PIX_W-1-brs_pkg::CH_W*c -: brs_pkg::CH_W]};
      end
    end
    for (int c = 0; c < 3; c++) begin
      top_next[c] = w0x * chan[brs_pkg::N_TL][c] + w1x * chan[brs_pkg::N_TR][c];
      bot_next[c] = w0x * chan[brs_pkg::N_BL][c] + w1x * chan[brs_pkg::N_BR][c];
    end
  end

  always_comb begin
    w1y = {dy2[FRAC_BITS], dy2};
    w0y = ONE - w1y;
    for (int c = 0; c < 3; c++) begin
      sum[c] = w0y * top2[c] + w1y * bot2[c];
      if (sum[c] <= LO_LIM) begin
        q[c]      = '0;
        clip_c[c] = 1'b1;
      end else if (sum[c] >= HI_LIM) begin
        q[c]      = '1;
        clip_c[c] = 1'b1;
      end else if (sum[c] < 0) begin
        q[c]      = '0;
        clip_c[c] = 1'b0;
      end else begin
        q[c]      = sum[c][2*FRAC_BITS+brs_pkg::CH_W-1 -: brs_pkg::CH_W];
        clip_c[c] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= pop && q_ctl.is_sample;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (oor2) begin
        red     <= '0;
        green   <= '0;
        blue    <= '0;
        clipped <= 1'b0;
      end else begin
        red     <= q[0];
        green   <= q[1];
        blue    <= q[2];
        clipped <= |clip_c;
      end
      out_of_range <= oor2;
    end
  end

  `ASSERT_IMPLIES(a_oor_blank, out_valid && out_of_range, red == '0 && green == '0 && blue == '0 && !clipped, "out-of-range result carries data")
  `ASSERT_NEXT(a_write_silent, pop && !q_ctl.is_sample, !v1, "pixel write entered the blend pipeline")
  `ASSERT_NEXT(a_stall_hold, v2 && !advance, out_valid && v2, "blend stage lost a transaction under stall")
endmodule

// File: hw/rtl/bilinear_rgb_sampler.sv
// Top level of the bilinear RGB sampler: configuration, front, queue, back
//
//  Channel | Handshake            | Carries
//  --------+----------------------+-------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (image width, height)
//  in      | in_valid/in_ready    | kind, write pixel, sample point
//  out     | out_valid/out_ready  | red, green, blue, out_of_range, clipped
//
// One transaction per cycle in each direction when nothing stalls; a sample result
// passes the front register, the queue and the back stages v1, v2 and out_valid.
// The four neighbours come from four copies of the pixel store, one read port each.
// Reset clears control state only; the pixel store holds nothing until written.
// A four-entry queue lets the input side run on while the result side stalls.
module bilinear_rgb_sampler #(
  parameter int MAX_PIXELS = 65536,
  parameter int FRAC_BITS  = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [brs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brs_pkg::COORD_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [brs_pkg::INDEX_W-1:0]       write_index,
  input  logic [brs_pkg::CH_W-1:0]          write_red,
  input  logic [brs_pkg::CH_W-1:0]          write_green,
  input  logic [brs_pkg::CH_W-1:0]          write_blue,
  input  logic [brs_pkg::SAMPLE_W-1:0]      sample_x,
  input  logic [brs_pkg::SAMPLE_W-1:0]      sample_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [brs_pkg::CH_W-1:0]          red,
  output logic [brs_pkg::CH_W-1:0]          green,
  output logic [brs_pkg::CH_W-1:0]          blue,
  output logic                              out_of_range,
  output logic                              clipped
);
  localparam int AW = $clog2(MAX_PIXELS);
  localparam int NB = brs_pkg::NEIGHBOURS;
  localparam int QW = $bits(brs_pkg::ctl_t) + NB * AW + 2 * (FRAC_BITS + 1) + brs_pkg::PIX_W;

  logic [brs_pkg::COORD_W-1:0] image_width;
  logic [brs_pkg::COORD_W-1:0] image_height;

  logic                          f_valid, f_ready;
  brs_pkg::ctl_t                 f_ctl, b_ctl;
  logic [NB-1:0][AW-1:0]         f_addr, b_addr;
  logic signed [FRAC_BITS:0]     f_dx, f_dy, b_dx, b_dy;
  logic [brs_pkg::PIX_W-1:0]     f_pixel, b_pixel;
  logic                          b_valid, b_ready;
  logic [QW-1:0]                 push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= brs_pkg::COORD_W'(256);
      image_height <= brs_pkg::COORD_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        brs_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        brs_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  brs_front #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .write_index  (write_index),
    .write_red    (write_red),
    .write_green  (write_green),
    .write_blue   (write_blue),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_ctl        (f_ctl),
    .q_addr       (f_addr),
    .q_dx         (f_dx),
    .q_dy         (f_dy),
    .q_pixel      (f_pixel)
  );

  assign push_data = {f_ctl, f_addr, f_dx, f_dy, f_pixel};
  assign {b_ctl, b_addr, b_dx, b_dy, b_pixel} = pop_data;

  brs_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (push_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (pop_data)
  );

  brs_back #(
    .FRAC_BITS  (FRAC_BITS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (b_valid),
    .q_ready      (b_ready),
    .q_ctl        (b_ctl),
    .q_addr       (b_addr),
    .q_dx         (b_dx),
    .q_dy         (b_dy),
    .q_pixel      (b_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_of_range (out_of_range),
    .clipped      (clipped)
  );
endmodule
